/* hdl/srcv_pkg.sv */
package srcv_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_RATE_MODE   = 3'd0;
    localparam logic [2:0] REG_LOW_MULT    = 3'd1;
    localparam logic [2:0] REG_COEF_A_ROLL = 3'd2;
    localparam logic [2:0] REG_COEF_B_ROLL = 3'd3;
    localparam logic [2:0] REG_COEF_A_PTCH = 3'd4;
    localparam logic [2:0] REG_COEF_B_PTCH = 3'd5;
    localparam logic [2:0] REG_COEF_A_YAW  = 3'd6;
    localparam logic [2:0] REG_COEF_B_YAW  = 3'd7;

    // rate_mode codes
    localparam logic [2:0] MODE_BOOST = 3'd0;
    localparam logic [2:0] MODE_BLEND = 3'd1;
    localparam logic [2:0] MODE_DIVX  = 3'd2;
    localparam logic [2:0] MODE_ACRO  = 3'd3;
    localparam logic [2:0] MODE_PLAIN = 3'd4;

    localparam logic [31:0] LOW_MULT_RESET = 32'd65536;
    localparam logic [1:0]  QDEPTH         = 2'd2;

    typedef enum logic [5:0] {
        CRV_BOOST = 6'b000001,
        CRV_BLEND = 6'b000010,
        CRV_DIVX  = 6'b000100,
        CRV_ACRO  = 6'b001000,
        CRV_PLAIN = 6'b010000,
        CRV_ZERO  = 6'b100000
    } curve_t;

    typedef struct packed {
        logic        s_neg;
        logic [15:0] s_mag;
        logic        p_neg;
        logic [15:0] p_mag;
    } axis_t;

    typedef struct packed {
        curve_t          curve;
        logic            high;
        axis_t [2:0]     ax;
    } cmd_t;

    typedef struct packed {
        logic [31:0]       low_mult;
        logic [2:0][31:0]  coef_a;
        logic [2:0][31:0]  coef_b;
        logic [2:0]        rate_mode;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic done;
    } lane_sts_t;

endpackage

/* hdl/srcv_front.sv */
module srcv_front import srcv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_shaped_roll,
    input  logic [15:0] s_shaped_pitch,
    input  logic [15:0] s_shaped_yaw,
    input  logic [15:0] s_plain_roll,
    input  logic [15:0] s_plain_pitch,
    input  logic [15:0] s_plain_yaw,
    input  logic        s_high_rates_on,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_din,
    output cfg_t        cfg
);

    cfg_t   cfg_reg;
    curve_t curve;

    function automatic axis_t split(input logic [15:0] s, input logic [15:0] p);
        axis_t a;
        a.s_neg = s[15];
        a.s_mag = s[15] ? 16'(-s) : s;
        a.p_neg = p[15];
        a.p_mag = p[15] ? 16'(-p) : p;
        return a;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate_mode <= MODE_BOOST;
            cfg_reg.low_mult  <= LOW_MULT_RESET;
            cfg_reg.coef_a    <= '0;
            cfg_reg.coef_b    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_RATE_MODE:   cfg_reg.rate_mode <= cfg_wdata[2:0];
                REG_LOW_MULT:    cfg_reg.low_mult  <= cfg_wdata;
                REG_COEF_A_ROLL: cfg_reg.coef_a[0] <= cfg_wdata;
                REG_COEF_B_ROLL: cfg_reg.coef_b[0] <= cfg_wdata;
                REG_COEF_A_PTCH: cfg_reg.coef_a[1] <= cfg_wdata;
                REG_COEF_B_PTCH: cfg_reg.coef_b[1] <= cfg_wdata;
                REG_COEF_A_YAW:  cfg_reg.coef_a[2] <= cfg_wdata;
                REG_COEF_B_YAW:  cfg_reg.coef_b[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_reg.rate_mode)
            MODE_BOOST: curve = CRV_BOOST;
            MODE_BLEND: curve = CRV_BLEND;
            MODE_DIVX:  curve = CRV_DIVX;
            MODE_ACRO:  curve = CRV_ACRO;
            MODE_PLAIN: curve = CRV_PLAIN;
            default:    curve = CRV_ZERO;
        endcase
    end

    assign s_ready     = !q_full;
    assign q_push      = s_valid && !q_full;
    assign q_din.curve = curve;
    assign q_din.high  = s_high_rates_on;
    assign q_din.ax[0] = split(s_shaped_roll, s_plain_roll);
    assign q_din.ax[1] = split(s_shaped_pitch, s_plain_pitch);
    assign q_din.ax[2] = split(s_shaped_yaw, s_plain_yaw);
    assign cfg         = cfg_reg;

endmodule

/* hdl/srcv_queue.sv */
module srcv_queue import srcv_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cmd_t       din,
    output logic       full,
    input  logic       pop,
    output cmd_t       dout,
    output logic       valid,
    output logic [1:0] count
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign full  = (cnt_reg == QDEPTH);
    assign valid = (cnt_reg != 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];
    assign count = cnt_reg;

endmodule

/* hdl/srcv_lane.sv */
module srcv_lane import srcv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        take,
    input  curve_t      curve,
    input  logic        high,
    input  axis_t       ax,
    input  logic [31:0] coef_a,
    input  logic [31:0] coef_b,
    input  logic [31:0] low_mult,
    output lane_sts_t   sts,
    output logic [31:0] rate
);

    localparam logic [63:0] BOOST_Q16 = 64'd952893;
    localparam logic [63:0] DEG2RAD   = 64'd74961321;
    localparam logic [27:0] LIM_Q16   = 28'd130940928;
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [16:0] FLOOR_Q16 = 17'd655;

    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_MUL  = 6'b000010,
        L_POST = 6'b000100,
        L_DIVS = 6'b001000,
        L_DIV  = 6'b010000,
        L_DONE = 6'b100000
    } lstate_t;

    typedef enum logic [3:0] {
        ST_BOOST, ST_M, ST_D, ST_RAD, ST_PA, ST_SB,
        ST_F, ST_X, ST_XF, ST_X4, ST_XD, ST_LOW
    } step_t;

    lstate_t            state_reg, state_next;
    step_t              step_reg, step_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [63:0]        mx_reg, mx_next, my_reg, my_next;
    logic [127:0]       acc_reg, acc_next;
    logic signed [63:0] term_reg, term_next;
    logic               fneg_reg, fneg_next;
    logic [27:0]        m_reg, m_next;
    logic [16:0]        d_reg, d_next;
    logic [16:0]        rem_reg, rem_next;
    logic [27:0]        nsh_reg, nsh_next;
    logic [27:0]        q_reg, q_next;
    logic [4:0]         dcnt_reg, dcnt_next;
    logic               neg_reg, neg_next;
    logic [31:0]        mag_reg, mag_next;
    curve_t             curve_reg, curve_next;
    logic               high_reg, high_next;
    axis_t              ax_reg, ax_next;

    logic [31:0]        mxl, myl;
    logic [63:0]        pp;
    logic [127:0]       pp_sh;
    logic               go, fin, fin_neg, hi_sel;
    logic [127:0]       fin_mag;
    logic [32:0]        norm_v;
    logic [127:0]       mt;
    logic [63:0]        t64, r64, p64, sum_abs;
    logic signed [63:0] sum, fsig;
    logic [44:0]        num;
    logic [17:0]        rem2;
    logic               ge;
    logic [27:0]        qn;

    // round half up, then drop sh bits
    function automatic logic [127:0] rshr(input logic [127:0] v, input int unsigned sh);
        logic [127:0] half;
        half = 128'd1 << (sh - 1);
        return (v + half) >> sh;
    endfunction

    // sign and magnitude as a saturated Q16.16 value: {neg, mag}
    function automatic logic [32:0] norm(input logic neg, input logic [127:0] mag);
        logic [32:0] r;
        if (mag == '0) begin
            r = '0;
        end else if (neg) begin
            r = (mag >= 128'h8000_0000) ? {1'b1, 32'h8000_0000} : {1'b1, mag[31:0]};
        end else begin
            r = (mag >= 128'h8000_0000) ? {1'b0, 32'h7FFF_FFFF} : {1'b0, mag[31:0]};
        end
        return r;
    endfunction

    function automatic logic [63:0] x200(input logic [63:0] v);
        return (v << 7) + (v << 6) + (v << 3);
    endfunction

    // 32x32 partial product, one limb pair per cycle
    always_comb begin
        mxl = cnt_reg[1] ? mx_reg[63:32] : mx_reg[31:0];
        myl = cnt_reg[0] ? my_reg[63:32] : my_reg[31:0];
        pp  = mxl * myl;
        unique case (cnt_reg)
            2'b00:         pp_sh = {64'd0, pp};
            2'b01, 2'b10:  pp_sh = {32'd0, pp, 32'd0};
            default:       pp_sh = {pp, 64'd0};
        endcase
    end

    assign hi_sel = (state_reg == L_IDLE) ? high : high_reg;
    assign norm_v = norm(fin_neg, fin_mag);
    assign p64    = acc_reg[63:0];

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        acc_next   = acc_reg;
        term_next  = term_reg;
        fneg_next  = fneg_reg;
        m_next     = m_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        nsh_next   = nsh_reg;
        q_next     = q_reg;
        dcnt_next  = dcnt_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        curve_next = curve_reg;
        high_next  = high_reg;
        ax_next    = ax_reg;
        go         = 1'b0;
        fin        = 1'b0;
        fin_neg    = 1'b0;
        fin_mag    = '0;
        mt         = '0;
        t64        = '0;
        r64        = '0;
        sum        = '0;
        sum_abs    = '0;
        fsig       = '0;
        num        = '0;
        rem2       = '0;
        ge         = 1'b0;
        qn         = '0;

        unique case (state_reg)
            L_IDLE: begin
                if (start) begin
                    curve_next = curve;
                    high_next  = high;
                    ax_next    = ax;
                    unique case (curve)
                        CRV_BOOST: begin
                            go = 1'b1;
                            if (coef_a > 32'h0002_0000) begin
                                mx_next   = {32'd0, coef_a - 32'h0002_0000};
                                my_next   = BOOST_Q16;
                                step_next = ST_BOOST;
                            end else begin
                                mx_next   = x200({32'd0, coef_a});
                                my_next   = {48'd0, ax.s_mag};
                                step_next = ST_M;
                            end
                        end
                        CRV_BLEND: begin
                            go        = 1'b1;
                            mx_next   = {48'd0, ax.p_mag};
                            my_next   = {32'd0, coef_a};
                            step_next = ST_PA;
                        end
                        CRV_DIVX: begin
                            // 2000 * |s| by shift and subtract
                            go        = 1'b1;
                            mx_next   = ({48'd0, ax.s_mag} << 11) - ({48'd0, ax.s_mag} << 5)
                                        - ({48'd0, ax.s_mag} << 4);
                            my_next   = {32'd0, coef_a};
                            step_next = ST_M;
                        end
                        CRV_ACRO: begin
                            go        = 1'b1;
                            mx_next   = {48'd0, ax.p_mag};
                            my_next   = {32'd0, coef_b};
                            step_next = ST_F;
                        end
                        CRV_PLAIN: begin
                            go        = 1'b1;
                            mx_next   = {48'd0, ax.s_mag};
                            my_next   = {32'd0, coef_a};
                            step_next = ST_X4;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            L_MUL: begin
                acc_next = acc_reg + pp_sh;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    state_next = L_POST;
                end
            end
            L_POST: begin
                unique case (step_reg)
                    ST_BOOST: begin
                        mt        = rshr(acc_reg, 16);
                        r64       = {32'd0, coef_a} + mt[63:0];
                        go        = 1'b1;
                        mx_next   = x200(r64);
                        my_next   = {48'd0, ax_reg.s_mag};
                        step_next = ST_M;
                    end
                    ST_M: begin
                        mt     = rshr(acc_reg, 15);
                        m_next = (mt > 128'(LIM_Q16)) ? LIM_Q16 : mt[27:0];
                        if (curve_reg == CRV_BOOST) begin
                            go        = 1'b1;
                            mx_next   = {48'd0, ax_reg.s_mag};
                            my_next   = {32'd0, coef_b};
                            step_next = ST_D;
                        end else if (!ax_reg.p_neg && ax_reg.p_mag != 16'd0) begin
                            go        = 1'b1;
                            mx_next   = {48'd0, ax_reg.p_mag};
                            my_next   = {32'd0, coef_b};
                            step_next = ST_D;
                        end else begin
                            d_next     = ONE_Q16;
                            state_next = L_DIVS;
                        end
                    end
                    ST_D: begin
                        mt  = rshr(acc_reg, 15);
                        t64 = mt[63:0];
                        if (t64 + 64'd655 >= 64'd65536) begin
                            d_next = FLOOR_Q16;
                        end else begin
                            d_next = 17'(64'd65536 - t64);
                        end
                        state_next = L_DIVS;
                    end
                    ST_RAD: begin
                        fin     = 1'b1;
                        fin_neg = ax_reg.s_neg;
                        fin_mag = rshr(acc_reg, 32);
                    end
                    ST_PA: begin
                        term_next = ax_reg.p_neg ? -$signed(p64) : $signed(p64);
                        go        = 1'b1;
                        mx_next   = {48'd0, ax_reg.s_mag};
                        my_next   = {32'd0, (coef_b > coef_a) ? coef_b - coef_a : 32'd0};
                        step_next = ST_SB;
                    end
                    ST_SB: begin
                        sum     = term_reg + (ax_reg.s_neg ? -$signed(p64) : $signed(p64));
                        sum_abs = sum[63] ? 64'(-sum) : 64'(sum);
                        fin     = 1'b1;
                        fin_neg = sum[63];
                        fin_mag = rshr({64'd0, sum_abs}, 15);
                    end
                    ST_F: begin
                        // factor 1 + p*B held in Q2.31 style scale (2^31 = 1.0)
                        fsig      = 64'sh8000_0000
                                    + (ax_reg.p_neg ? -$signed(p64) : $signed(p64));
                        fneg_next = fsig[63];
                        term_next = fsig[63] ? -fsig : fsig;
                        go        = 1'b1;
                        mx_next   = {48'd0, ax_reg.s_mag};
                        my_next   = {32'd0, coef_a};
                        step_next = ST_X;
                    end
                    ST_X: begin
                        go        = 1'b1;
                        mx_next   = p64;
                        my_next   = 64'(term_reg);
                        step_next = ST_XF;
                    end
                    ST_XF: begin
                        fin     = 1'b1;
                        fin_neg = ax_reg.s_neg ^ fneg_reg;
                        fin_mag = rshr(acc_reg, 46);
                    end
                    ST_X4: begin
                        go        = 1'b1;
                        mx_next   = p64;
                        my_next   = DEG2RAD;
                        step_next = ST_XD;
                    end
                    ST_XD: begin
                        fin     = 1'b1;
                        fin_neg = ax_reg.s_neg;
                        fin_mag = rshr(acc_reg, 47);
                    end
                    ST_LOW: begin
                        {neg_next, mag_next} = norm(neg_reg, rshr(acc_reg, 16));
                        state_next           = L_DONE;
                    end
                    default: begin
                        state_next = L_DONE;
                    end
                endcase
            end
            L_DIVS: begin
                num = {1'b0, m_reg, 16'd0} + 45'(d_reg >> 1);
                if (num >= {d_reg, 28'd0}) begin
                    // quotient already past the clamp
                    go        = 1'b1;
                    mx_next   = {36'd0, LIM_Q16};
                    my_next   = DEG2RAD;
                    step_next = ST_RAD;
                end else begin
                    rem_next   = num[44:28];
                    nsh_next   = num[27:0];
                    q_next     = '0;
                    dcnt_next  = '0;
                    state_next = L_DIV;
                end
            end
            L_DIV: begin
                rem2      = {rem_reg, nsh_reg[27]};
                ge        = (rem2 >= {1'b0, d_reg});
                rem_next  = ge ? 17'(rem2 - {1'b0, d_reg}) : rem2[16:0];
                nsh_next  = {nsh_reg[26:0], 1'b0};
                qn        = {q_reg[26:0], ge};
                q_next    = qn;
                dcnt_next = dcnt_reg + 5'd1;
                if (dcnt_reg == 5'd27) begin
                    go        = 1'b1;
                    mx_next   = {36'd0, (qn > LIM_Q16) ? LIM_Q16 : qn};
                    my_next   = DEG2RAD;
                    step_next = ST_RAD;
                end
            end
            L_DONE: begin
                if (take) begin
                    state_next = L_IDLE;
                end
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase

        // curve value ready: saturate, then optional low-rate scaling
        if (fin) begin
            neg_next = norm_v[32];
            mag_next = norm_v[31:0];
            if (hi_sel) begin
                state_next = L_DONE;
            end else begin
                go        = 1'b1;
                mx_next   = {32'd0, norm_v[31:0]};
                my_next   = {32'd0, low_mult};
                step_next = ST_LOW;
            end
        end

        if (go) begin
            state_next = L_MUL;
            cnt_next   = 2'd0;
            acc_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg  <= step_next;
        cnt_reg   <= cnt_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        acc_reg   <= acc_next;
        term_reg  <= term_next;
        fneg_reg  <= fneg_next;
        m_reg     <= m_next;
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        nsh_reg   <= nsh_next;
        q_reg     <= q_next;
        dcnt_reg  <= dcnt_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        curve_reg <= curve_next;
        high_reg  <= high_next;
        ax_reg    <= ax_next;
    end

    assign sts.idle = (state_reg == L_IDLE);
    assign sts.done = (state_reg == L_DONE);
    assign rate     = neg_reg ? 32'(-mag_reg) : mag_reg;

endmodule

/* hdl/srcv_back.sv */
module srcv_back import srcv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  cmd_t        q_dout,
    output logic        q_pop,
    output logic        lanes_idle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_rate_roll,
    output logic [31:0] m_rate_pitch,
    output logic [31:0] m_rate_yaw
);

    lane_sts_t [2:0]   sts;
    logic [2:0][31:0]  rate;
    logic [2:0]        idle_v, done_v;
    logic              all_done, take;
    logic              m_valid_reg, m_valid_next;
    logic [2:0][31:0]  out_reg;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        srcv_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (q_pop),
            .take     (take),
            .curve    (q_dout.curve),
            .high     (q_dout.high),
            .ax       (q_dout.ax[i]),
            .coef_a   (cfg.coef_a[i]),
            .coef_b   (cfg.coef_b[i]),
            .low_mult (cfg.low_mult),
            .sts      (sts[i]),
            .rate     (rate[i])
        );
        assign idle_v[i] = sts[i].idle;
        assign done_v[i] = sts[i].done;
    end

    assign lanes_idle = &idle_v;
    assign all_done   = &done_v;
    assign q_pop      = q_valid && lanes_idle;
    assign take       = all_done && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= rate;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_rate_roll  = out_reg[0];
    assign m_rate_pitch = out_reg[1];
    assign m_rate_yaw   = out_reg[2];

endmodule

/* hdl/stick_to_rate_curve_core.sv */
// Stick to angular rate curves, three axes.
// Input beats (s_valid/s_ready) carry shaped and plain stick values per axis
// in Q1.15 and the high-rates flag; output beats (m_valid/m_ready) carry the
// roll, pitch and yaw rate setpoints in signed Q16.16, saturated.
// Configuration: cfg_we/cfg_index/cfg_wdata, to be written only while idle;
// the block does not enforce this. The front classifies each beat against
// rate_mode into a two-entry queue; the back runs one engine per axis, all
// three in parallel. Each engine has one 32x32 multiplier used four times
// per product and a one-bit-per-cycle divider. Per item, from queue pop to
// result handoff, modes 1, 3 and 4 run only multiplier products; modes 0
// and 2 also run the divider unless the quotient is already past the clamp;
// unused modes run no curve product and give zero. Low rates add a product
// by the low-rate multiplier.
// A new item enters the queue while the current one is computed and while a
// finished result waits in the output register; a stalled receiver holds
// the result and, once the queue fills, s_ready drops.
// Reset: registers return to mode 0, low-rate multiplier 1.0, coefficients
// 0; queue and output are empty.
module stick_to_rate_curve_core import srcv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_shaped_roll,
    input  logic [15:0] s_shaped_pitch,
    input  logic [15:0] s_shaped_yaw,
    input  logic [15:0] s_plain_roll,
    input  logic [15:0] s_plain_pitch,
    input  logic [15:0] s_plain_yaw,
    input  logic        s_high_rates_on,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_rate_roll,
    output logic [31:0] m_rate_pitch,
    output logic [31:0] m_rate_yaw
);

    cfg_t       cfg;
    cmd_t       q_din, q_dout;
    logic       q_push, q_full, q_pop, q_valid, lanes_idle;
    logic [1:0] q_count;

    srcv_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_shaped_roll   (s_shaped_roll),
        .s_shaped_pitch  (s_shaped_pitch),
        .s_shaped_yaw    (s_shaped_yaw),
        .s_plain_roll    (s_plain_roll),
        .s_plain_pitch   (s_plain_pitch),
        .s_plain_yaw     (s_plain_yaw),
        .s_high_rates_on (s_high_rates_on),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_din           (q_din),
        .cfg             (cfg)
    );

    srcv_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .valid   (q_valid),
        .count   (q_count)
    );

    srcv_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_dout       (q_dout),
        .q_pop        (q_pop),
        .lanes_idle   (lanes_idle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_rate_roll  (m_rate_roll),
        .m_rate_pitch (m_rate_pitch),
        .m_rate_yaw   (m_rate_yaw)
    );

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (q_count != 2'd0))
        else $error("queue popped while empty");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> !lanes_idle)
        else $error("axis engines did not start");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop) |=> (q_count != 2'd0))
        else $error("accepted beat lost in queue");

endmodule
